// ===== hdl/vbpw_pkg.sv =====
// Shared types and constants for the video RAM byte to pixel write expander.
// Used by vbpw_front, vbpw_queue, vbpw_back and vram_byte_to_pixel_writes.
`default_nettype none

package vbpw_pkg;

  // Display modes, as coded in the display_mode register
  typedef enum logic [1:0] {
    MODE_COLOUR32 = 2'd0,
    MODE_MONO64   = 2'd1,
    MODE_COLOUR64 = 2'd2,
    MODE_MONO128  = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE      = 2'd2;

  // Field widths
  localparam int ADDR_W  = 11;
  localparam int BYTE_W  = 8;
  localparam int CLR_W   = 4;
  localparam int COORD_W = 7;
  localparam int PIX_W   = 2 * COORD_W;

  // Reset values of the registers
  localparam mode_t             MODE_RESET = MODE_MONO64;
  localparam logic [CLR_W-1:0]  FG_RESET   = '0;

  // Back end step counter: 8 writes for quadrant modes, 32 for scaled modes
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_LAST_SHORT = 5'd7;
  localparam logic [CNT_W-1:0] CNT_LAST_LONG  = 5'd31;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified item as the back end executes it
  typedef struct packed {
    logic               frame;
    mode_t              mode;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [BYTE_W-1:0]  value;
    logic [CLR_W-1:0]   fg;
    logic               pal;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/vbpw_front.sv =====
// Front end: configuration registers and classification of incoming items.
// Depends on vbpw_pkg.
`default_nettype none

module vbpw_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [vbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vbpw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            take,
  input  wire logic                            frame_select,
  input  wire logic [vbpw_pkg::ADDR_W-1:0]     byte_address,
  input  wire logic [vbpw_pkg::BYTE_W-1:0]     byte_value,
  output logic                                 push,
  output vbpw_pkg::cmd_t                       cmd
);

  vbpw_pkg::mode_t                  display_mode;
  logic [vbpw_pkg::CLR_W-1:0]       foreground_colour;
  logic                             colour_palette;
  logic                             quad_mode;
  logic                             keep;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode      <= vbpw_pkg::MODE_RESET;
      foreground_colour <= vbpw_pkg::FG_RESET;
      colour_palette    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vbpw_pkg::REG_DISPLAY_MODE: begin
          display_mode <= vbpw_pkg::mode_t'(cfg_data[1:0]);
        end
        vbpw_pkg::REG_FOREGROUND: begin
          foreground_colour <= cfg_data[vbpw_pkg::CLR_W-1:0];
        end
        vbpw_pkg::REG_PALETTE: begin
          colour_palette <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Base pixel of the item. Quadrant modes place the 512-byte page on screen;
  // scaled modes drop anything past the first page (it lands below the frame).
  always_comb begin
    quad_mode = (display_mode == vbpw_pkg::MODE_MONO128) ||
                (display_mode == vbpw_pkg::MODE_COLOUR64);
    cmd.frame = frame_select;
    cmd.mode  = display_mode;
    cmd.value = byte_value;
    cmd.fg    = foreground_colour;
    cmd.pal   = colour_palette;
    if (quad_mode) begin
      cmd.base_x = {byte_address[9], byte_address[3:0], 2'b00};
      cmd.base_y = {byte_address[10], byte_address[8:4], 1'b0};
      keep       = 1'b1;
    end else begin
      cmd.base_x = {byte_address[3:0], 3'b000};
      cmd.base_y = {byte_address[8:4], 2'b00};
      keep       = (byte_address[10:9] == 2'b00);
    end
    push = take && keep;
  end

endmodule

`default_nettype wire

// ===== hdl/vbpw_queue.sv =====
// Short register queue of classified items between front and back end.
// Depends on vbpw_pkg.
`default_nettype none

module vbpw_queue #(
  parameter int DEPTH = vbpw_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire vbpw_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output vbpw_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  vbpw_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== hdl/vbpw_back.sv =====
// Back end: steps through the pixel writes of one item, one per cycle.
// Depends on vbpw_pkg.
`default_nettype none

module vbpw_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire vbpw_pkg::cmd_t               head,
  input  wire logic                         empty,
  output logic                              pop,
  output logic                              result_strobe,
  output logic                              target_buffer,
  output logic [vbpw_pkg::PIX_W-1:0]        pixel_index,
  output logic [vbpw_pkg::CLR_W-1:0]        colour_index,
  output logic                              palette_select,
  output logic                              last_write
);

  vbpw_pkg::cmd_t                 cmd;
  logic                           active;
  logic [vbpw_pkg::CNT_W-1:0]     cnt;
  logic [vbpw_pkg::CNT_W-1:0]     cnt_last;
  logic                           finish;
  logic [2:0]                     dx;
  logic [1:0]                     dy;
  logic [vbpw_pkg::CLR_W-1:0]     clr;
  logic [vbpw_pkg::COORD_W-1:0]   px;
  logic [vbpw_pkg::COORD_W-1:0]   py;

  // Offset and colour of the current step
  always_comb begin
    case (cmd.mode)
      vbpw_pkg::MODE_MONO64: begin
        dx       = {cnt[4], cnt[2], cnt[0]};
        dy       = {cnt[3], cnt[1]};
        clr      = cmd.value[cnt[4:2]] ? cmd.fg : '0;
        cnt_last = vbpw_pkg::CNT_LAST_LONG;
      end
      vbpw_pkg::MODE_COLOUR64: begin
        dx       = {1'b0, cnt[2], cnt[0]};
        dy       = {1'b0, cnt[1]};
        clr      = cnt[2] ? cmd.value[7:4] : cmd.value[3:0];
        cnt_last = vbpw_pkg::CNT_LAST_SHORT;
      end
      vbpw_pkg::MODE_COLOUR32: begin
        dx       = {cnt[4], cnt[1:0]};
        dy       = cnt[3:2];
        clr      = cnt[4] ? cmd.value[7:4] : cmd.value[3:0];
        cnt_last = vbpw_pkg::CNT_LAST_LONG;
      end
      default: begin
        dx       = {1'b0, cnt[2], cnt[0]};
        dy       = {1'b0, cnt[1]};
        clr      = cmd.value[cnt[2:0]] ? cmd.fg : '0;
        cnt_last = vbpw_pkg::CNT_LAST_SHORT;
      end
    endcase
    px     = cmd.base_x + {4'b0000, dx};
    py     = cmd.base_y + {5'b00000, dy};
    finish = active && (cnt == cnt_last);
    pop    = (!active || finish) && !empty;
  end

  // Sequencer: load next item as the current one ends
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (finish) begin
      active <= 1'b0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      last_write    <= 1'b0;
    end else begin
      result_strobe <= active;
      last_write    <= finish;
    end
  end

  always_ff @(posedge clk) begin
    target_buffer  <= cmd.frame;
    pixel_index    <= {py, px};
    colour_index   <= clr;
    palette_select <= cmd.pal;
  end

`ifndef SYNTH
  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_write |-> result_strobe)
    else $error("last flag without a result");
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_write) |=> result_strobe)
    else $error("gap inside the writes of one item");
`endif

endmodule

`default_nettype wire

// ===== hdl/vram_byte_to_pixel_writes.sv =====
// Top level of the video RAM byte to pixel write expander.
// Depends on vbpw_pkg, vbpw_front, vbpw_queue and vbpw_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  item in  | start / busy         | frame_select, byte_address, byte_value
//  result   | result_strobe        | target_buffer, pixel_index, colour_index,
//           |                      | palette_select, last_write
//  config   | cfg_we               | cfg_index, cfg_data
//
// An item gives 8 writes (128x128 mono, 64x64 colour) or 32 writes (64x64 mono,
// 32x32 colour), one per cycle, set by the back end step counter; an item in a
// scaled mode at address 512 or above gives none. An accepted item passes
// through the queue and the back end, and writes of queued items follow without gaps.
// Reset (rst, synchronous) sets display_mode 1, foreground 0, palette 0 and
// empties the queue. busy is high while the queue is full; results cannot be held.
`default_nettype none

module vram_byte_to_pixel_writes #(
  parameter int QUEUE_DEPTH = vbpw_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [vbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vbpw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            frame_select,
  input  wire logic [vbpw_pkg::ADDR_W-1:0]     byte_address,
  input  wire logic [vbpw_pkg::BYTE_W-1:0]     byte_value,
  output logic                                 result_strobe,
  output logic                                 target_buffer,
  output logic [vbpw_pkg::PIX_W-1:0]           pixel_index,
  output logic [vbpw_pkg::CLR_W-1:0]           colour_index,
  output logic                                 palette_select,
  output logic                                 last_write
);

  logic           take;
  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  vbpw_pkg::cmd_t push_cmd;
  vbpw_pkg::cmd_t head;

  // Item accepted whenever the queue has room
  assign busy = full;
  assign take = start && !full;

  vbpw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .frame_select (frame_select),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .push         (push),
    .cmd          (push_cmd)
  );

  vbpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  vbpw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .result_strobe  (result_strobe),
    .target_buffer  (target_buffer),
    .pixel_index    (pixel_index),
    .colour_index   (colour_index),
    .palette_select (palette_select),
    .last_write     (last_write)
  );

endmodule

`default_nettype wire

// ===== dv/vbpw_pixel_checker.sv =====
// Scoreboard for the video RAM byte to pixel write expander: tracks register writes,
// expands each accepted byte into the pixel writes it should cause, compares results.
// Depends on vbpw_pkg for the display mode codes, register indexes and field widths.
`default_nettype none

module vbpw_pixel_checker
  import vbpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic                  frame_select,
  input  wire logic [ADDR_W-1:0]     byte_address,
  input  wire logic [BYTE_W-1:0]     byte_value,
  input  wire logic                  result_strobe,
  input  wire logic                  target_buffer,
  input  wire logic [PIX_W-1:0]      pixel_index,
  input  wire logic [CLR_W-1:0]      colour_index,
  input  wire logic                  palette_select,
  input  wire logic                  last_write,
  output int                         mismatch_count,
  output int                         pending_count,
  output int                         writes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_DIM  = 128;
  localparam int MAX_WRITES = 32;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic             buffer;
    logic [PIX_W-1:0] pixel;
    logic [CLR_W-1:0] colour;
    logic             palette;
    logic             last;
  } pix_write_t;

  // Shadow copy of the registers
  mode_t            disp_mode;
  logic [CLR_W-1:0] fg_colour;
  logic             pal_sel;

  pix_write_t expected_writes[$];

  // The newest write of a run is held back so the final one can be flagged
  pix_write_t held_write;
  bit         have_held;
  int         run_len;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    writes_checked = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: MISMATCH %s: got %0d, expected %0d (pixel write %0d)",
               $realtime, what, got, want, writes_checked);
    mismatch_count++;
  endtask

  // One pixel write; anything off the frame or past the run limit is dropped
  task automatic emit_pixel(input logic buffer, input int x, input int y,
                            input logic [CLR_W-1:0] colour);
    pix_write_t w;
    if (x < FRAME_DIM && y < FRAME_DIM && run_len < MAX_WRITES) begin
      if (have_held) expected_writes.push_back(held_write);
      w.buffer   = buffer;
      w.pixel    = PIX_W'(y * FRAME_DIM + x);
      w.colour   = colour;
      w.palette  = pal_sel;
      w.last     = 1'b0;
      held_write = w;
      have_held  = 1'b1;
      run_len++;
    end
  endtask

  // Scaled cell; dropped whole when its top-left corner is off the frame
  task automatic emit_block(input logic buffer, input int cx, input int cy, input int scale,
                            input logic [CLR_W-1:0] colour);
    int bx;
    int by;
    bx = cx * scale;
    by = cy * scale;
    if (bx < FRAME_DIM && by < FRAME_DIM) begin
      for (int j = 0; j < scale; j++)
        for (int i = 0; i < scale; i++)
          emit_pixel(buffer, bx + i, by + j, colour);
    end
  endtask

  // Expected pixel writes for one video RAM byte under the current registers
  task automatic expand_byte(input logic buffer, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] value);
    int a;
    int q;
    int x;
    int y;
    int dx;
    int dy;
    logic [CLR_W-1:0] c;
    a = int'(addr) % 512;
    q = int'(addr) / 512;
    run_len   = 0;
    have_held = 1'b0;
    case (disp_mode)
      MODE_MONO128: begin
        y = (a / 16) * 2 + (((q >> 1) != 0) ? 64 : 0);
        x = (a * 4) % 64 + (((q & 1) != 0) ? 64 : 0);
        for (int k = 0; k < 8; k++) begin
          // bit order: 0,1 top pair, 2,3 bottom pair, then the same two columns over
          dx = (k & 1) + ((k >> 2) & 1) * 2;
          dy = (k >> 1) & 1;
          c  = value[k] ? fg_colour : '0;
          emit_pixel(buffer, x + dx, y + dy, c);
        end
      end
      MODE_MONO64: begin
        y = (int'(addr) / 16) * 2;
        x = (int'(addr) * 4) % 64;
        for (int k = 0; k < 8; k++) begin
          dx = (k & 1) + ((k >> 2) & 1) * 2;
          dy = (k >> 1) & 1;
          c  = value[k] ? fg_colour : '0;
          emit_block(buffer, x + dx, y + dy, 2, c);
        end
      end
      MODE_COLOUR64: begin
        y = a / 16 + (((q >> 1) != 0) ? 32 : 0);
        x = (a * 2) % 32 + (((q & 1) != 0) ? 32 : 0);
        emit_block(buffer, x, y, 2, value[3:0]);
        emit_block(buffer, x + 1, y, 2, value[7:4]);
      end
      default: begin
        y = int'(addr) / 16;
        x = (int'(addr) * 2) % 32;
        emit_block(buffer, x, y, 4, value[3:0]);
        emit_block(buffer, x + 1, y, 4, value[7:4]);
      end
    endcase
    if (have_held) begin
      held_write.last = 1'b1;
      expected_writes.push_back(held_write);
      have_held = 1'b0;
    end
  endtask

  // Sample all channels at the rising edge, before the block updates
  always @(posedge clk) begin : watch
    pix_write_t want;
    if (rst) begin
      disp_mode = MODE_RESET;
      fg_colour = FG_RESET;
      pal_sel   = 1'b0;
      expected_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DISPLAY_MODE: disp_mode = mode_t'(cfg_data[1:0]);
          REG_FOREGROUND:   fg_colour = cfg_data[CLR_W-1:0];
          REG_PALETTE:      pal_sel   = cfg_data[0];
          default: ;
        endcase
      end
      if (result_strobe) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("pixel write with none expected", int'(pixel_index), -1);
        end else begin
          want = expected_writes.pop_front();
          if (target_buffer !== want.buffer)
            report_mismatch("target_buffer", int'(target_buffer), int'(want.buffer));
          if (pixel_index !== want.pixel)
            report_mismatch("pixel_index", int'(pixel_index), int'(want.pixel));
          if (colour_index !== want.colour)
            report_mismatch("colour_index", int'(colour_index), int'(want.colour));
          if (palette_select !== want.palette)
            report_mismatch("palette_select", int'(palette_select), int'(want.palette));
          if (last_write !== want.last)
            report_mismatch("last_write", int'(last_write), int'(want.last));
          writes_checked++;
        end
      end
      if (start && !busy)
        expand_byte(frame_select, byte_address, byte_value);
    end
    pending_count <= expected_writes.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench top for vram_byte_to_pixel_writes: clock, reset, register settings and byte
// writes with random sender gaps; the verdict comes from vbpw_pixel_checker.
// Depends on vbpw_pkg, vbpw_pixel_checker and the block itself.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vbpw_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int BYTES_PER_PASS = 24;
  // no register sits at this index; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  start;
  logic                  busy;
  logic                  frame_select;
  logic [ADDR_W-1:0]     byte_address;
  logic [BYTE_W-1:0]     byte_value;
  logic                  result_strobe;
  logic                  target_buffer;
  logic [PIX_W-1:0]      pixel_index;
  logic [CLR_W-1:0]      colour_index;
  logic                  palette_select;
  logic                  last_write;

  int mismatch_count;
  int pending_count;
  int writes_checked;
  int bytes_sent;
  int settings_used;
  int quiet_cycles;

  vram_byte_to_pixel_writes DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .frame_select   (frame_select),
    .byte_address   (byte_address),
    .byte_value     (byte_value),
    .result_strobe  (result_strobe),
    .target_buffer  (target_buffer),
    .pixel_index    (pixel_index),
    .colour_index   (colour_index),
    .palette_select (palette_select),
    .last_write     (last_write)
  );

  vbpw_pixel_checker pixel_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .frame_select   (frame_select),
    .byte_address   (byte_address),
    .byte_value     (byte_value),
    .result_strobe  (result_strobe),
    .target_buffer  (target_buffer),
    .pixel_index    (pixel_index),
    .colour_index   (colour_index),
    .palette_select (palette_select),
    .last_write     (last_write),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .writes_checked (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: too long with no register write, no accepted byte and no pixel write
  always @(posedge clk) begin
    if (rst || cfg_we || result_strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte after an optional gap and hold it until accepted
  task automatic send_byte(input logic f, input logic [ADDR_W-1:0] a,
                           input logic [BYTE_W-1:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    frame_select <= f;
    byte_address <= a;
    byte_value   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off until every expected write is out, then let stray no-result bytes finish
  task automatic wait_idle();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] mode_data,
                               input logic [CFG_DATA_W-1:0] fg_data,
                               input logic [CFG_DATA_W-1:0] pal_data,
                               input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DISPLAY_MODE;
    cfg_data  <= mode_data;
    @(posedge clk);
    cfg_index <= REG_FOREGROUND;
    cfg_data  <= fg_data;
    @(posedge clk);
    cfg_index <= REG_PALETTE;
    cfg_data  <= pal_data;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Scaled modes mostly get addresses that land on the frame
  function automatic logic [ADDR_W-1:0] pick_address(input mode_t m);
    if ((m == MODE_MONO64 || m == MODE_COLOUR32) && $urandom_range(0, 99) < 85)
      return ADDR_W'($urandom_range(0, 511));
    return ADDR_W'($urandom);
  endfunction

  // Directed bytes: address corners, quadrant starts, all-ones/all-zeros and nibble splits
  task automatic directed_pass();
    send_byte(1'b0, 11'd0,    8'hFF, 0);
    send_byte(1'b1, 11'd511,  8'h00, 0);
    send_byte(1'b0, 11'd512,  8'hA5, 0);
    send_byte(1'b1, 11'd1024, 8'h5A, 2);
    send_byte(1'b0, 11'd1536, 8'h0F, 0);
    send_byte(1'b1, 11'd2047, 8'hF0, 0);
    start <= 1'b0;
    wait_idle();
  endtask

  initial begin
    mode_t            mode;
    logic [CLR_W-1:0] fg;
    logic             pal;
    bit               no_gaps;
    int               gap;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    start        <= 1'b0;
    frame_select <= 1'b0;
    byte_address <= '0;
    byte_value   <= '0;
    bytes_sent    = 0;
    settings_used = 0;
    quiet_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: one pass per display mode, foreground 0, 0xA or 0xF, both palette values
    set_registers({2'b00, MODE_MONO128}, 4'hF, 4'h1, 1'b1);
    directed_pass();
    set_registers({2'b11, MODE_MONO64}, 4'hA, 4'hE, 1'b0);
    directed_pass();
    set_registers({2'b01, MODE_COLOUR64}, 4'h0, 4'h1, 1'b0);
    directed_pass();
    set_registers({2'b10, MODE_COLOUR32}, 4'hF, 4'h0, 1'b0);
    directed_pass();

    // Random passes: every mode first, then random settings; pass 3 and the last pass have no gaps
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(0, 3));
      fg   = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : CLR_W'($urandom);
      pal  = (p < 2) ? p[0] : 1'($urandom);
      set_registers({2'($urandom), mode}, fg, {3'($urandom), pal}, p == 5);
      no_gaps = (p == RANDOM_PHASES - 1) || (p == 3);
      for (int i = 0; i < BYTES_PER_PASS; i++) begin
        gap = (!no_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        send_byte(1'($urandom), pick_address(mode), BYTE_W'($urandom), gap);
      end
      start <= 1'b0;
      wait_idle();
    end

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte writes under %0d register settings in all four display modes,",
             bytes_sent, settings_used);
    $display("with %0d pixel writes compared field by field.", writes_checked);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
